// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion helpers for the page allocator
// clocked on i_clk, switched off while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every edge
`define PCFL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// same-cycle implication
`define PCFL_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PCFL_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/pcfl_pkg.sv =====
// ----------------------------------------------------------------------------
// pcfl_pkg
// shared constants, codes and helpers of the per-core page free list allocator
// ----------------------------------------------------------------------------
package pcfl_pkg;

    // field widths
    localparam int ADDR_W    = 56;
    localparam int OP_W      = 2;
    localparam int CORE_ID_W = 3;
    localparam int STATUS_W  = 2;

    // configuration port
    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 4;

    // default sizing
    localparam int DEF_NUM_CORES  = 8;
    localparam int DEF_NUM_PAGES  = 32768;
    localparam int DEF_PAGE_BYTES = 4096;

    // register reset values
    localparam logic [ADDR_W-1:0] START_RESET = 56'h00_0000_8000_0000;
    localparam logic [ADDR_W-1:0] STOP_RESET  = 56'h00_0000_8800_0000;

    // register indexes
    localparam logic REG_START = 1'b0;
    localparam logic REG_STOP  = 1'b1;

    // operation codes
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_INIT  = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_ADDR = 2'd2;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DEC,
        S_FCHK,
        S_ALLOC_WB,
        S_INIT,
        S_FIN
    } t_state;

    // core id folded into the configured core count
    function automatic logic [CORE_ID_W-1:0] core_mod(input logic [CORE_ID_W-1:0] id,
                                                       input int unsigned n);
        logic [CORE_ID_W-1:0] v;
        v = id;
        for (int i = 0; i < 8; i++) begin
            if (int'(v) >= n) begin
                v = v - CORE_ID_W'(n);
            end
        end
        return v;
    endfunction

endpackage

// ===== rtl/core/pcfl_link_ram.sv =====
// ----------------------------------------------------------------------------
// pcfl_link_ram
// next-link store, one write and one registered read port
// ----------------------------------------------------------------------------
module pcfl_link_ram #(
    parameter int DEPTH = 32768,
    parameter int AW    = 15,
    parameter int DW    = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered output
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/per_core_page_free_list_allocator.sv =====
// ----------------------------------------------------------------------------
// per_core_page_free_list_allocator
// each item passes S_DEC, then S_ALLOC_WB for alloc, S_FCHK for free or
// S_INIT for init (one link write a cycle), then S_FIN and the output register
// an unused op or an alloc with every list empty goes from S_DEC to S_FIN;
// a new item is taken in S_FIN of the previous one once the output is free
// synchronous reset empties every list and loads the region registers;
// the link memory keeps its contents, there is no clearing pass
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module per_core_page_free_list_allocator #(
    parameter int NUM_CORES  = pcfl_pkg::DEF_NUM_CORES,
    parameter int NUM_PAGES  = pcfl_pkg::DEF_NUM_PAGES,
    parameter int PAGE_BYTES = pcfl_pkg::DEF_PAGE_BYTES  // power of two
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [63:0]                         s_axis_tdata,  // core_id, page_addr, zero pad
    input  logic [pcfl_pkg::OP_W-1:0]           s_axis_tuser,  // op
    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [pcfl_pkg::ADDR_W-1:0]         m_axis_tdata,  // alloc_addr
    output logic [pcfl_pkg::STATUS_W-1:0]       m_axis_tuser,  // status
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pcfl_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [pcfl_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [pcfl_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int AW   = pcfl_pkg::ADDR_W;
    localparam int CIW  = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
    localparam int PIW  = $clog2(NUM_PAGES);
    localparam int PW   = $clog2(NUM_PAGES + 1);
    localparam int SH   = $clog2(PAGE_BYTES);
    localparam int CIDW = pcfl_pkg::CORE_ID_W;

    // configuration registers
    logic [AW-1:0] r_start;
    logic [AW-1:0] r_stop;

    // sequencer and item registers
    pcfl_pkg::t_state          r_state, n_state;
    logic [pcfl_pkg::OP_W-1:0] r_op;
    logic [CIW-1:0]            r_core;
    logic [AW-1:0]             r_addr;
    logic [AW:0]               r_base;

    // list heads, coded as page + 1 with zero for empty
    logic [PW-1:0]        r_head [NUM_CORES];
    logic [NUM_CORES-1:0] r_valid;
    logic [NUM_CORES-1:0] w_head_nz;

    // alloc and free working registers
    logic [CIW-1:0] r_sel;
    logic [PIW-1:0] r_page;
    logic           r_aligned, r_ge_start, r_lt_stop;

    // init walk
    logic [PW-1:0] r_n;
    logic [AW:0]   r_a;

    // result staging and output register
    logic [pcfl_pkg::STATUS_W-1:0] r_res_status;
    logic [AW-1:0]                 r_res_addr;
    logic                          r_m_valid;
    logic [pcfl_pkg::STATUS_W-1:0] r_m_status;
    logic [AW-1:0]                 r_m_addr;

    // link memory port
    logic          w_ram_we, w_ram_re;
    logic [PIW-1:0] w_ram_waddr, w_ram_raddr;
    logic [PW-1:0]  w_ram_wdata, w_ram_rdata;

    // combinational helpers
    logic                 w_in_fire, w_out_free, w_cfg_wr;
    logic [AW:0]          w_base;
    logic [CIDW-1:0]      w_core_mod;
    logic [CIW+CIDW-1:0]  w_core_wide;
    logic [NUM_CORES-1:0] w_other;
    logic [CIW-1:0]       w_first, w_sel;
    logic                 w_any;
    logic [PW-1:0]        w_sel_head;
    logic [AW:0]          w_diff;
    logic [AW:0]          w_pgnum;
    logic                 w_free_ok;
    logic [AW+1:0]        w_a_next;
    logic                 w_init_more;
    logic [AW:0]          w_alloc_sum;

    // handshakes
    assign w_out_free    = !r_m_valid || m_axis_tready;
    assign s_axis_tready = (r_state == pcfl_pkg::S_IDLE) ||
                           ((r_state == pcfl_pkg::S_FIN) && w_out_free);
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;
    assign w_cfg_wr      = psel && penable && pwrite && pready;

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_addr;
    assign m_axis_tuser  = r_m_status;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[3] == pcfl_pkg::REG_STOP) ? {8'b0, r_stop} : {8'b0, r_start};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= pcfl_pkg::START_RESET;
            r_stop  <= pcfl_pkg::STOP_RESET;
        end else if (w_cfg_wr) begin
            if (paddr[3] == pcfl_pkg::REG_STOP) begin
                r_stop <= pwdata[AW-1:0];
            end else begin
                r_start <= pwdata[AW-1:0];
            end
        end
    end

    // page base: region start rounded up to a page boundary
    assign w_base = ({1'b0, r_start} + (AW+1)'(PAGE_BYTES - 1)) &
                    ~((AW+1)'(PAGE_BYTES - 1));

    // incoming core id folded into range
    assign w_core_mod  = pcfl_pkg::core_mod(s_axis_tdata[CIDW-1:0], NUM_CORES);
    assign w_core_wide = {{CIW{1'b0}}, w_core_mod};

    // owner list first, else the lowest-numbered other nonempty list
    always_comb begin
        w_other = r_valid;
        w_other[r_core] = 1'b0;
        w_first = '0;
        for (int i = NUM_CORES - 1; i >= 0; i--) begin
            if (w_other[i]) begin
                w_first = CIW'(i);
            end
        end
        w_any = |r_valid;
        w_sel = r_valid[r_core] ? r_core : w_first;
    end
    assign w_sel_head = r_head[w_sel];

    // free address check, page number relative to the base
    assign w_diff    = {1'b0, r_addr} - r_base;
    assign w_pgnum   = w_diff >> SH;
    assign w_free_ok = r_aligned && r_ge_start && r_lt_stop &&
                       (w_pgnum < (AW+1)'(NUM_PAGES));

    // init walk continues while pages remain and a whole page still fits below the stop
    assign w_a_next    = {1'b0, r_a} + (AW+2)'(PAGE_BYTES);
    assign w_init_more = (r_n < PW'(NUM_PAGES)) && (w_a_next <= {2'b0, r_stop});

    // address of the popped page
    assign w_alloc_sum = r_base + ((AW+1)'(r_page) << SH);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pcfl_pkg::S_IDLE: begin
                if (w_in_fire) n_state = pcfl_pkg::S_DEC;
            end
            pcfl_pkg::S_DEC: begin
                case (r_op)
                    pcfl_pkg::OP_ALLOC: n_state = w_any ? pcfl_pkg::S_ALLOC_WB
                                                        : pcfl_pkg::S_FIN;
                    pcfl_pkg::OP_FREE:  n_state = pcfl_pkg::S_FCHK;
                    pcfl_pkg::OP_INIT:  n_state = pcfl_pkg::S_INIT;
                    default:            n_state = pcfl_pkg::S_FIN;
                endcase
            end
            pcfl_pkg::S_FCHK:     n_state = pcfl_pkg::S_FIN;
            pcfl_pkg::S_ALLOC_WB: n_state = pcfl_pkg::S_FIN;
            pcfl_pkg::S_INIT: begin
                if (!w_init_more) n_state = pcfl_pkg::S_FIN;
            end
            pcfl_pkg::S_FIN: begin
                if (w_out_free) begin
                    n_state = w_in_fire ? pcfl_pkg::S_DEC : pcfl_pkg::S_IDLE;
                end
            end
            default: n_state = pcfl_pkg::S_IDLE;
        endcase
    end

    // link memory controls
    always_comb begin
        w_ram_we    = 1'b0;
        w_ram_waddr = '0;
        w_ram_wdata = '0;
        w_ram_re    = 1'b0;
        w_ram_raddr = PIW'(w_sel_head - PW'(1));
        case (r_state)
            pcfl_pkg::S_DEC: begin
                w_ram_re = (r_op == pcfl_pkg::OP_ALLOC) && w_any;
            end
            pcfl_pkg::S_FCHK: begin
                w_ram_we    = w_free_ok;
                w_ram_waddr = PIW'(w_pgnum);
                w_ram_wdata = r_head[r_core];
            end
            pcfl_pkg::S_INIT: begin
                w_ram_we    = w_init_more;
                w_ram_waddr = r_n[PIW-1:0];
                w_ram_wdata = r_n;
            end
            default: begin
                w_ram_we = 1'b0;
            end
        endcase
    end

    pcfl_link_ram #(
        .DEPTH (NUM_PAGES),
        .AW    (PIW),
        .DW    (PW)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // state and list heads
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pcfl_pkg::S_IDLE;
            r_valid <= '0;
            for (int i = 0; i < NUM_CORES; i++) begin
                r_head[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            case (r_state)
                pcfl_pkg::S_DEC: begin
                    if (r_op == pcfl_pkg::OP_INIT) begin
                        r_valid <= '0;
                        for (int i = 0; i < NUM_CORES; i++) begin
                            r_head[i] <= '0;
                        end
                    end
                end
                pcfl_pkg::S_FCHK: begin
                    if (w_free_ok) begin
                        r_head[r_core]  <= PW'(w_pgnum) + PW'(1);
                        r_valid[r_core] <= 1'b1;
                    end
                end
                pcfl_pkg::S_ALLOC_WB: begin
                    r_head[r_sel]  <= w_ram_rdata;
                    r_valid[r_sel] <= (w_ram_rdata != '0);
                end
                pcfl_pkg::S_INIT: begin
                    if (w_init_more) begin
                        r_head[r_core]  <= r_n + PW'(1);
                        r_valid[r_core] <= 1'b1;
                    end
                end
                default: begin
                    r_valid <= r_valid;
                end
            endcase
        end
    end

    // item capture and datapath registers
    always_ff @(posedge i_clk) begin
        r_base <= w_base;
        if (w_in_fire) begin
            r_op   <= s_axis_tuser;
            r_core <= w_core_wide[CIW-1:0];
            r_addr <= s_axis_tdata[CIDW+AW-1:CIDW];
        end
        case (r_state)
            pcfl_pkg::S_DEC: begin
                r_res_status <= pcfl_pkg::STATUS_OK;
                r_res_addr   <= '0;
                if ((r_op == pcfl_pkg::OP_ALLOC) && !w_any) begin
                    r_res_status <= pcfl_pkg::STATUS_EMPTY;
                end
                r_sel      <= w_sel;
                r_page     <= PIW'(w_sel_head - PW'(1));
                r_aligned  <= (r_addr[SH-1:0] == '0);
                r_ge_start <= (r_addr >= r_start);
                r_lt_stop  <= (r_addr < r_stop);
                r_n        <= '0;
                r_a        <= w_base;
            end
            pcfl_pkg::S_FCHK: begin
                if (!w_free_ok) begin
                    r_res_status <= pcfl_pkg::STATUS_BAD_ADDR;
                end
            end
            pcfl_pkg::S_ALLOC_WB: begin
                r_res_addr <= w_alloc_sum[AW-1:0];
            end
            pcfl_pkg::S_INIT: begin
                if (w_init_more) begin
                    r_n <= r_n + PW'(1);
                    r_a <= w_a_next[AW:0];
                end
            end
            default: begin
                r_n <= r_n;
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if ((r_state == pcfl_pkg::S_FIN) && w_out_free) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == pcfl_pkg::S_FIN) && w_out_free) begin
            r_m_status <= r_res_status;
            r_m_addr   <= r_res_addr;
        end
    end

    // nonempty view of the heads for checking
    always_comb begin
        for (int i = 0; i < NUM_CORES; i++) begin
            w_head_nz[i] = (r_head[i] != '0);
        end
    end

    // checks
    `PCFL_ASSERT(a_valid_tracks_heads, r_valid == w_head_nz, "nonempty mask out of step with heads")
    `PCFL_ASSERT(a_ram_one_access, !(w_ram_we && w_ram_re), "link memory read and written together")
    `PCFL_NEXT(a_accept_decodes, w_in_fire, r_state == pcfl_pkg::S_DEC, "accepted item not decoded")
    `PCFL_NEXT(a_pop_takes_link, r_state == pcfl_pkg::S_ALLOC_WB, r_head[r_sel] == $past(w_ram_rdata), "pop lost the link")
    `PCFL_IMPLY(a_empty_no_addr, m_axis_tvalid && (m_axis_tuser == pcfl_pkg::STATUS_EMPTY), m_axis_tdata == '0, "empty result carries an address")

endmodule

// ===== dv/per_core_page_free_list_allocator_tb.sv =====
// ----------------------------------------------------------------------------
// per_core_page_free_list_allocator_tb
// self-checking bench for the per-core page free list allocator: a directed
// table of corner requests, then random phases, each with its own region,
// checked result by result against an in-bench model of the core lists
// ----------------------------------------------------------------------------
module per_core_page_free_list_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pcfl_pkg::*;

    localparam int          NUM_CORES       = DEF_NUM_CORES;
    localparam int          NUM_PAGES       = DEF_NUM_PAGES;
    localparam int          PAGE_BYTES      = DEF_PAGE_BYTES;
    localparam logic [63:0] ADDR_MASK       = 64'h00FF_FFFF_FFFF_FFFF;
    localparam logic [63:0] PAGE_MASK       = 64'(PAGE_BYTES - 1);
    localparam int          EDGE_PHASES     = 3;
    localparam int          RAND_PHASES     = 10;
    localparam int          ITEMS_PER_PHASE = 73;
    localparam int          RAND_TOTAL      = (EDGE_PHASES + RAND_PHASES) * ITEMS_PER_PHASE;
    localparam int          LONG_HOLD       = 300;
    localparam int          QUIET_LIMIT     = 150000;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   addr;
    } result_t;

    typedef struct {
        logic [OP_W-1:0]      op;
        logic [CORE_ID_W-1:0] core;
        logic [ADDR_W-1:0]    addr;
        bit                   typed;
        result_t              want;
    } stim_row_t;

    // clock, reset and block ports
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [63:0]           s_axis_tdata  = '0;  // core_id, page_addr, zero pad
    logic [OP_W-1:0]       s_axis_tuser  = '0;  // op
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [ADDR_W-1:0]     m_axis_tdata;        // alloc_addr
    logic [STATUS_W-1:0]   m_axis_tuser;        // status
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [APB_ADDR_W-1:0] paddr         = '0;
    logic [APB_DATA_W-1:0] pwdata        = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // bench state
    bit                req_typed   = 1'b0;
    result_t           req_want    = '0;
    int                tx_idle_pct = 20;
    int                rx_idle_pct = 54;
    bit                hold_go     = 1'b0;
    int                mismatches  = 0;
    int                quiet_cycles = 0;
    result_t           due_results[$];
    logic [ADDR_W-1:0] granted_pages[$];

    // model of the lists: links and heads coded as page number plus one
    logic [63:0] cfg_start = 64'(START_RESET);
    logic [63:0] cfg_stop  = 64'(STOP_RESET);
    int unsigned link_mem[NUM_PAGES];
    int unsigned head_of[NUM_CORES];

    per_core_page_free_list_allocator u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // region start rounded up to a whole page
    function automatic logic [63:0] page_base(input logic [63:0] start);
        return (start + PAGE_MASK) & ~PAGE_MASK;
    endfunction

    function automatic void push_page(input int unsigned core, input int unsigned page);
        link_mem[page] = head_of[core];
        head_of[core]  = page + 1;
    endfunction

    function automatic bit pop_page(input int unsigned core, output int unsigned page);
        int unsigned h;
        h    = head_of[core];
        page = 0;
        if (h == 0 || h > NUM_PAGES) begin
            return 1'b0;
        end
        page          = h - 1;
        head_of[core] = link_mem[page];
        return 1'b1;
    endfunction

    // expected result of one request, lists updated as a side effect
    function automatic result_t predict_page_op(input logic [OP_W-1:0]      op,
                                                input logic [CORE_ID_W-1:0] core_in,
                                                input logic [ADDR_W-1:0]    addr_in);
        result_t     r;
        logic [63:0] base;
        logic [63:0] a;
        logic [63:0] pa;
        int unsigned c;
        int unsigned page;
        int unsigned n;
        bit          got;
        r    = '0;
        c    = int'(core_in) % NUM_CORES;
        pa   = 64'(addr_in);
        base = page_base(cfg_start);
        case (op)
            OP_INIT: begin
                for (int i = 0; i < NUM_CORES; i++) begin
                    head_of[i] = 0;
                end
                n = 0;
                a = base;
                while (n < NUM_PAGES && a + 64'(PAGE_BYTES) <= cfg_stop) begin
                    push_page(c, n);
                    n++;
                    a = a + 64'(PAGE_BYTES);
                end
                granted_pages.delete();
            end
            OP_FREE: begin
                if ((pa & PAGE_MASK) != 0 || pa < cfg_start || pa >= cfg_stop) begin
                    r.status = STATUS_BAD_ADDR;
                end else if ((pa - base) / 64'(PAGE_BYTES) >= 64'(NUM_PAGES)) begin
                    r.status = STATUS_BAD_ADDR;
                end else begin
                    push_page(c, int'((pa - base) / 64'(PAGE_BYTES)));
                end
            end
            OP_ALLOC: begin
                got = pop_page(c, page);
                for (int i = 0; i < NUM_CORES; i++) begin
                    if (!got && i != c) begin
                        got = pop_page(i, page);
                    end
                end
                if (got) begin
                    r.addr = ADDR_W'(base + 64'(page) * 64'(PAGE_BYTES));
                    granted_pages.push_back(r.addr);
                end else begin
                    r.status = STATUS_EMPTY;
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic stim_row_t mk_row(input logic [OP_W-1:0]      op,
                                         input logic [CORE_ID_W-1:0] core,
                                         input logic [ADDR_W-1:0]    addr,
                                         input bit                   typed,
                                         input logic [STATUS_W-1:0]  status,
                                         input logic [ADDR_W-1:0]    got);
        stim_row_t row;
        row.op          = op;
        row.core        = core;
        row.addr        = addr;
        row.typed       = typed;
        row.want.status = status;
        row.want.addr   = got;
        return row;
    endfunction

    // predict each request as it is accepted
    always @(posedge i_clk) begin : request_monitor
        result_t r;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            r = predict_page_op(s_axis_tuser, s_axis_tdata[CORE_ID_W-1:0],
                                s_axis_tdata[CORE_ID_W +: ADDR_W]);
            due_results.push_back(req_typed ? req_want : r);
        end
    end

    // compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin : result_checker
        result_t w;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (due_results.size() == 0) begin
                $display("%0t: result with none expected: status %0d addr %h",
                         $time, m_axis_tuser, m_axis_tdata);
                mismatches++;
            end else begin
                w = due_results.pop_front();
                if (m_axis_tuser !== w.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, w.status, m_axis_tuser);
                    mismatches++;
                end
                if (m_axis_tdata !== w.addr) begin
                    $display("%0t: alloc_addr expected %h actual %h",
                             $time, w.addr, m_axis_tdata);
                    mismatches++;
                end
            end
        end
    end

    // cycles with no transfer on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    // result side: random back-pressure plus one long hold-off on request
    initial begin : result_sink
        forever begin
            @(negedge i_clk);
            if (hold_go) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                hold_go = 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // offer one request and wait for its transfer; called on a falling edge
    task automatic offer_request(input logic [OP_W-1:0]      op,
                                 input logic [CORE_ID_W-1:0] core,
                                 input logic [ADDR_W-1:0]    addr,
                                 input bit                   typed,
                                 input result_t              want);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct && gap < 12) begin
            gap++;
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {{(64 - ADDR_W - CORE_ID_W){1'b0}}, addr, core};
        req_typed     <= typed;
        req_want      <= want;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    // wait for every outstanding result, then let the block settle
    task automatic drain_results();
        while (due_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (8) @(negedge i_clk);
    endtask

    // register write then read-back; upper pad bits of pwdata are randomised
    task automatic write_reg(input logic idx, input logic [63:0] value);
        logic [63:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value | (64'($urandom_range(255)) << ADDR_W);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        if (idx == REG_START) begin
            cfg_start = value & ADDR_MASK;
        end else begin
            cfg_stop = value & ADDR_MASK;
        end
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        rd = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== (value & ADDR_MASK)) begin
            $display("%0t: register %0d read expected %h actual %h",
                     $time, idx, value & ADDR_MASK, rd);
            mismatches++;
        end
    endtask

    initial begin : stimulus
        stim_row_t         rows[$];
        stim_row_t         row;
        logic [63:0]       start_v;
        logic [63:0]       stop_v;
        logic [63:0]       base_v;
        logic [ADDR_W-1:0] addr_v;
        logic [OP_W-1:0]   op_v;
        int unsigned       span;
        int                pick;
        int                idx;
        int                sent;
        bit                big;

        for (int i = 0; i < NUM_CORES; i++) begin
            head_of[i] = 0;
        end
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed corners on the reset region
        rows.push_back(mk_row(OP_ALLOC, 3'd0, '0, 1, STATUS_EMPTY, '0));
        rows.push_back(mk_row(OP_NOP, 3'd7, '1, 1, STATUS_OK, '0));
        rows.push_back(mk_row(OP_FREE, 3'd0, '0, 1, STATUS_BAD_ADDR, '0));
        rows.push_back(mk_row(OP_FREE, 3'd1, 56'h8000_0001, 1, STATUS_BAD_ADDR, '0));
        rows.push_back(mk_row(OP_FREE, 3'd2, 56'h8800_0000, 1, STATUS_BAD_ADDR, '0));
        rows.push_back(mk_row(OP_FREE, 3'd3, '1, 1, STATUS_BAD_ADDR, '0));
        rows.push_back(mk_row(OP_FREE, 3'd3, 56'h8000_0000, 1, STATUS_OK, '0));
        rows.push_back(mk_row(OP_ALLOC, 3'd5, '1, 1, STATUS_OK, 56'h8000_0000));
        rows.push_back(mk_row(OP_ALLOC, 3'd5, '0, 1, STATUS_EMPTY, '0));
        rows.push_back(mk_row(OP_FREE, 3'd7, 56'h87FF_F000, 1, STATUS_OK, '0));
        rows.push_back(mk_row(OP_FREE, 3'd7, 56'h8000_1000, 1, STATUS_OK, '0));
        rows.push_back(mk_row(OP_ALLOC, 3'd7, 56'hA5_5A5A_5A5A_5A5A, 1, STATUS_OK,
                              56'h8000_1000));
        rows.push_back(mk_row(OP_ALLOC, 3'd0, '0, 1, STATUS_OK, 56'h87FF_F000));
        // double free: the same page goes on the list twice
        rows.push_back(mk_row(OP_FREE, 3'd4, 56'h8000_2000, 1, STATUS_OK, '0));
        rows.push_back(mk_row(OP_FREE, 3'd4, 56'h8000_2000, 1, STATUS_OK, '0));
        rows.push_back(mk_row(OP_ALLOC, 3'd4, '0, 1, STATUS_OK, 56'h8000_2000));
        rows.push_back(mk_row(OP_ALLOC, 3'd6, '0, 1, STATUS_OK, 56'h8000_2000));
        // init over the whole reset region fills every page
        rows.push_back(mk_row(OP_INIT, 3'd2, '1, 1, STATUS_OK, '0));
        rows.push_back(mk_row(OP_ALLOC, 3'd2, '0, 1, STATUS_OK, 56'h87FF_F000));
        rows.push_back(mk_row(OP_ALLOC, 3'd6, '0, 1, STATUS_OK, 56'h87FF_E000));
        rows.push_back(mk_row(OP_FREE, 3'd6, 56'h8000_0000, 0, STATUS_OK, '0));
        rows.push_back(mk_row(OP_ALLOC, 3'd1, '0, 0, STATUS_OK, '0));
        rows.push_back(mk_row(OP_ALLOC, 3'd6, '0, 0, STATUS_OK, '0));
        rows.push_back(mk_row(OP_NOP, 3'd0, '0, 1, STATUS_OK, '0));
        foreach (rows[i]) begin
            row = rows[i];
            offer_request(row.op, row.core, row.addr, row.typed, row.want);
        end

        // random phases: full region, top-of-range region, empty region, then small ones
        sent   = 0;
        base_v = '0;
        span   = 16;
        for (int ph = 0; ph < EDGE_PHASES + RAND_PHASES; ph++) begin
            s_axis_tvalid <= 1'b0;
            drain_results();
            big = (ph == 0);
            if (ph == 0) begin
                start_v = '0;
                stop_v  = ADDR_MASK;
                span    = 40000;
            end else if (ph == 1) begin
                start_v = ADDR_MASK;
                stop_v  = ADDR_MASK;
                span    = 16;
            end else begin
                start_v = 64'({$urandom, $urandom}) & ADDR_MASK;
                if (start_v > ADDR_MASK - 64'h40_0000) begin
                    start_v = start_v - 64'h80_0000;
                end
                if (start_v < 64'h4000) begin
                    start_v = start_v + 64'h4000;
                end
                if ($urandom_range(1) == 1) begin
                    start_v = start_v & ~PAGE_MASK;
                end
                span = $urandom_range(16, 200);
                if (ph == 2) begin
                    stop_v = start_v - 64'($urandom_range(1, 1000));
                end else begin
                    stop_v = page_base(start_v) + 64'(span) * 64'(PAGE_BYTES)
                             + 64'($urandom_range(0, PAGE_BYTES - 1));
                end
            end
            write_reg(REG_START, start_v);
            write_reg(REG_STOP, stop_v);
            base_v = page_base(start_v);

            // mostly start from fresh lists; otherwise old pages show at the new base
            if (ph == 0 || (ph > 1 && $urandom_range(99) < 80)) begin
                offer_request(OP_INIT, CORE_ID_W'($urandom), ADDR_W'({$urandom, $urandom}),
                              0, '0);
                sent++;
            end
            if (ph == EDGE_PHASES) begin
                hold_go = 1'b1;
            end

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (sent < RAND_TOTAL / 3) begin
                    tx_idle_pct = 20;
                    rx_idle_pct = 54;
                end else if (sent < 2 * RAND_TOTAL / 3) begin
                    tx_idle_pct = 54;
                    rx_idle_pct = 20;
                end else begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
                pick   = $urandom_range(99);
                addr_v = ADDR_W'({$urandom, $urandom});
                op_v   = OP_ALLOC;
                if (pick >= 42 && pick < 77) begin
                    // well-formed free, mostly a page handed out earlier
                    op_v = OP_FREE;
                    if (granted_pages.size() > 0 && $urandom_range(99) < 75) begin
                        idx    = $urandom_range(granted_pages.size() - 1);
                        addr_v = granted_pages[idx];
                        granted_pages.delete(idx);
                    end else begin
                        addr_v = ADDR_W'(base_v + 64'($urandom_range(0, span + 2))
                                         * 64'(PAGE_BYTES));
                    end
                end else if (pick >= 77 && pick < 87) begin
                    // misaligned or wild free
                    op_v = OP_FREE;
                    if ($urandom_range(1) == 1) begin
                        addr_v = ADDR_W'(base_v + 64'($urandom_range(0, span))
                                         * 64'(PAGE_BYTES)
                                         + 64'($urandom_range(1, PAGE_BYTES - 1)));
                    end
                end else if (pick >= 87 && pick < 94) begin
                    op_v   = OP_FREE;
                    addr_v = ADDR_W'(base_v + 64'($urandom_range(0, span + span / 4))
                                     * 64'(PAGE_BYTES));
                end else if (pick >= 94 && pick < 97) begin
                    op_v = OP_NOP;
                end else if (pick >= 97 && !big) begin
                    op_v = OP_INIT;
                end
                offer_request(op_v, CORE_ID_W'($urandom), addr_v, 0, '0);
                sent++;
            end
        end

        s_axis_tvalid <= 1'b0;
        drain_results();
        if (mismatches == 0 && due_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/pcfl_pkg.sv
rtl/core/pcfl_link_ram.sv
rtl/core/per_core_page_free_list_allocator.sv
dv/per_core_page_free_list_allocator_tb.sv
